/* hw/rtl/cil_pkg.sv */
// Package with sizes, codes and cell control type for the compacting indexed list.
`timescale 1ns / 1ps

package cil_pkg;

    localparam int CAPACITY = 64;
    localparam int CIDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 6;
    localparam int ECNT_W   = 7;
    localparam int CMP_W    = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
    localparam int DATA_W   = 32;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic              wr;
        logic [CIDX_W-1:0] wr_pos;
        logic              shift;
        logic [CIDX_W-1:0] idx;
        word_t             value;
    } cell_ctl_t;

    function automatic logic [CIDX_W-1:0] to_pos(input logic [IDX_W-1:0] i);
        logic [CMP_W-1:0] w;
        begin
            w = CMP_W'(i);
            return w[CIDX_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/cil_ifs.sv */
// Request and response channel interfaces of the compacting indexed list.
`timescale 1ns / 1ps

interface cil_req_if;
    import cil_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  index;
    word_t             value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface cil_rsp_if;
    import cil_pkg::*;
    logic              valid;
    logic              ready;
    word_t             read_data;
    logic [1:0]        status;
    logic [ECNT_W-1:0] entry_count;

    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

/* hw/rtl/cil_cell.sv */
// One storage cell of the list: write, shift down from its upper neighbor, read select.
`timescale 1ns / 1ps

module cil_cell
    import cil_pkg::*;
(
    input  logic              clk,
    input  logic [CIDX_W-1:0] pos,
    input  cell_ctl_t         ctl,
    input  word_t             upper,
    output word_t             data,
    output word_t             rd
);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.wr && (pos == ctl.wr_pos))
        begin
            data_next = ctl.value;
        end
        else if (ctl.shift && (pos >= ctl.idx))
        begin
            data_next = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign rd   = (pos == ctl.idx) ? data_reg : '0;

endmodule

/* hw/rtl/compacting_indexed_list_top.sv */
// Top level of the compacting indexed list: command decode, count, cell chain, result register.
//
//  channel | dir | fields                              | accepted when
//  req     | in  | cmd[1:0] index[5:0] value[31:0]     | req.valid && req.ready
//  rsp     | out | read_data[31:0] status[1:0]         | rsp.valid && rsp.ready
//          |     | entry_count[6:0]                    |
//
// The result of every command is registered and shows the next cycle.
// A removal shifts all later cells down one place in that same cycle through the chain.
// Reset clears the count and the result valid; cell contents stay undefined.
// req.ready drops only while a result waits and rsp.ready is low.
`timescale 1ns / 1ps

module compacting_indexed_list_top
    import cil_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cil_req_if.sink       req,
    cil_rsp_if.source     rsp
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    word_t             read_data_reg;
    word_t             read_data_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [ECNT_W-1:0] entry_count_reg;
    logic [CMP_W-1:0]  cnt_wide;

    logic              accept;
    logic              in_range;
    logic              full;
    cell_ctl_t         ctl;
    word_t             cell_data [CAPACITY];
    word_t             cell_rd   [CAPACITY];
    word_t             rd_bus;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign in_range  = CMP_W'(req.index) < CMP_W'(count_reg);
    assign full      = count_reg == CNT_W'(CAPACITY);

    assign read_data_next = ((req.cmd == CMD_READ) && in_range) ? rd_bus : '0;

    always_comb
    begin
        ctl            = '0;
        ctl.idx        = to_pos(req.index);
        ctl.value      = req.value;
        count_next     = count_reg;
        status_next    = ST_OK;
        unique case (req.cmd)
            CMD_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.wr     = accept;
                    ctl.wr_pos = count_reg[CIDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
            end
            CMD_UPDATE:
            begin
                if (in_range)
                begin
                    ctl.wr     = accept;
                    ctl.wr_pos = to_pos(req.index);
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            CMD_REMOVE:
            begin
                if (in_range)
                begin
                    ctl.shift  = accept;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            cil_cell u_cell (
                .clk   (clk),
                .pos   (CIDX_W'(g)),
                .ctl   (ctl),
                .upper ((g + 1 < CAPACITY) ? cell_data[(g + 1) % CAPACITY] : '0),
                .data  (cell_data[g]),
                .rd    (cell_rd[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    assign cnt_wide = CMP_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg   <= read_data_next;
            status_reg      <= status_next;
            entry_count_reg <= cnt_wide[ECNT_W-1:0];
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule

/* hw/rtl/cil_checker.sv */
// Port-level checker for the compacting indexed list, bound to the top level.
`timescale 1ns / 1ps

module cil_checker
    import cil_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input word_t             read_data,
    input logic [1:0]        status,
    input logic [ECNT_W-1:0] entry_count
);

    localparam logic [CMP_W-1:0]  CAP_WIDE = CMP_W'(CAPACITY);
    localparam logic [ECNT_W-1:0] CAP_ECNT = CAP_WIDE[ECNT_W-1:0];

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("accepted item gave no result");

    a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_OK) |-> (read_data == '0))
        else $error("failed command returned data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_FULL) |-> (entry_count == CAP_ECNT))
        else $error("full status without full count");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_data)
            && $stable(status) && $stable(entry_count)))
        else $error("stalled result changed");

endmodule

bind compacting_indexed_list_top cil_checker u_cil_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_data   (rsp.read_data),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
);

/* bench/cil_list_checker.sv */
`timescale 1ns / 1ps
// Checker for the compacting indexed list: predicts every result from the accepted commands.

module cil_list_checker
    import cil_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cil_req_if   req,
    cil_rsp_if   rsp,
    output int   errors,
    output int   outstanding,
    output int   list_len
);

    typedef struct packed {
        word_t             read_data;
        logic [1:0]        status;
        logic [ECNT_W-1:0] entry_count;
    } list_rsp_t;

    word_t     list_store [CAPACITY];
    int        store_len = 0;
    int        fail_count = 0;
    list_rsp_t expected_rsp [$];

    assign errors = fail_count;

    task automatic apply_command(input logic [1:0] c, input logic [IDX_W-1:0] i,
                                 input word_t v, output list_rsp_t r);
        int pos;
        int k;
        begin
            r = '0;
            r.status = ST_OK;
            pos = int'(i);
            if (c == CMD_APPEND)
            begin
                if (store_len >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    list_store[store_len] = v;
                    store_len++;
                end
            end
            else if (pos >= store_len || pos >= CAPACITY)
            begin
                r.status = ST_RANGE;
            end
            else if (c == CMD_READ)
            begin
                r.read_data = list_store[pos];
            end
            else if (c == CMD_UPDATE)
            begin
                list_store[pos] = v;
            end
            else
            begin
                for (k = pos; k + 1 < store_len; k++)
                begin
                    list_store[k] = list_store[k + 1];
                end
                store_len--;
            end
            r.entry_count = ECNT_W'(store_len);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_rsp_t want;
        list_rsp_t fresh;
        if (!rst_n)
        begin
            store_len = 0;
            expected_rsp.delete();
            outstanding <= 0;
            list_len <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    $error("result with no command waiting: read_data %0d status %0d count %0d",
                           rsp.read_data, rsp.status, rsp.entry_count);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        fail_count++;
                        $error("read_data: expected %0d, got %0d", want.read_data,
                               rsp.read_data);
                    end
                    if (rsp.status !== want.status)
                    begin
                        fail_count++;
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        fail_count++;
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               rsp.entry_count);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                apply_command(req.cmd, req.index, req.value, fresh);
                expected_rsp.push_back(fresh);
            end
            outstanding <= expected_rsp.size();
            list_len <= store_len;
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the compacting indexed list: clock, reset, commands, watchdog and verdict.

module tb_top;
    import cil_pkg::*;

    localparam int NUM_ITEMS   = 1050;
    localparam int LONG_HOLD   = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   list_len;
    logic idle_on = 1'b1;
    logic hold_rsp = 1'b0;
    int   quiet_cycles = 0;
    int   sent = 0;

    cil_req_if req_ch ();
    cil_rsp_if rsp_ch ();

    compacting_indexed_list_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cil_list_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (errors),
        .outstanding (outstanding),
        .list_len    (list_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_cmd(input logic [1:0] c, input logic [IDX_W-1:0] i, input word_t v);
        int gap;
        begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req_ch.valid <= 1'b1;
            req_ch.cmd   <= c;
            req_ch.index <= i;
            req_ch.value <= v;
            @(posedge clk);
            while (!req_ch.ready) @(posedge clk);
            sent++;
        end
    endtask

    task automatic send_random(input phase_kind_t kind);
        logic [1:0]       c;
        logic [IDX_W-1:0] i;
        word_t            v;
        int               roll;
        begin
            roll = $urandom_range(0, 99);
            c = 2'($urandom_range(0, 3));
            if (kind == PH_FILL && roll < 85)
            begin
                c = CMD_APPEND;
            end
            else if (kind == PH_DRAIN && roll < 65)
            begin
                c = CMD_REMOVE;
            end
            roll = $urandom_range(0, 9);
            if (list_len > 0 && roll < 7)
            begin
                i = IDX_W'($urandom_range(0, list_len - 1));
            end
            else if (roll == 7)
            begin
                i = IDX_W'(list_len);
            end
            else
            begin
                i = IDX_W'($urandom);
            end
            v = word_t'($urandom);
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            send_cmd(c, i, v);
        end
    endtask

    task automatic wait_drained();
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0) @(posedge clk);
        end
    endtask

    initial
    begin
        int          phase_no;
        int          span;
        phase_kind_t kind;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd   <= CMD_APPEND;
        req_ch.index <= '0;
        req_ch.value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(CMD_READ,   6'd0,  '0);
        send_cmd(CMD_UPDATE, 6'd0,  32'sh1234_5678);
        send_cmd(CMD_REMOVE, 6'd63, '0);
        send_cmd(CMD_APPEND, 6'd63, 32'sh7FFF_FFFF);
        send_cmd(CMD_APPEND, 6'd0,  32'sh8000_0000);
        send_cmd(CMD_APPEND, 6'd0,  '0);
        send_cmd(CMD_APPEND, 6'd0,  '1);
        send_cmd(CMD_APPEND, 6'd0,  32'sh5555_5555);
        send_cmd(CMD_READ,   6'd0,  '1);
        send_cmd(CMD_READ,   6'd4,  '0);
        send_cmd(CMD_READ,   6'd5,  '0);
        send_cmd(CMD_READ,   6'd63, '0);
        send_cmd(CMD_UPDATE, 6'd2,  32'shAAAA_AAAA);
        send_cmd(CMD_READ,   6'd2,  '0);
        send_cmd(CMD_UPDATE, 6'd5,  32'sh0F0F_0F0F);
        send_cmd(CMD_REMOVE, 6'd0,  '0);
        send_cmd(CMD_REMOVE, 6'd3,  '0);
        send_cmd(CMD_REMOVE, 6'd1,  '0);
        send_cmd(CMD_READ,   6'd0,  '0);
        send_cmd(CMD_READ,   6'd1,  '0);
        send_cmd(CMD_REMOVE, 6'd2,  '0);

        phase_no = 0;
        while (sent < NUM_ITEMS)
        begin
            if (phase_no == 0)
            begin
                kind = PH_FILL;
            end
            else if (phase_no == 1)
            begin
                kind = PH_DRAIN;
            end
            else
            begin
                kind = phase_kind_t'($urandom_range(0, 2));
            end
            idle_on = (phase_no % 4 != 3);
            if (phase_no == 2 || phase_no == 7)
            begin
                hold_rsp = 1'b1;
            end
            span = (phase_no < 2) ? 100 : $urandom_range(40, 120);
            repeat (span) send_random(kind);
            if (phase_no % 3 == 1)
            begin
                wait_drained();
            end
            phase_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

/* files.f */
hw/rtl/cil_pkg.sv
hw/rtl/cil_ifs.sv
hw/rtl/cil_cell.sv
hw/rtl/compacting_indexed_list_top.sv
hw/rtl/cil_checker.sv
bench/cil_list_checker.sv
bench/tb_top.sv
